/* sv/jzq_pkg.sv */
package jzq_pkg;

  // Field widths of the words on the two channels, the block size and the index, divisor and step widths.
  localparam int DATA_W     = 16;
  localparam int COMP_W     = 3;
  localparam int BLOCK_SIZE = 64;
  localparam int IDX_W      = 6;
  localparam int DIV_W      = 8;
  localparam int STEP_W     = 4;

  localparam logic [IDX_W-1:0]  LAST_INDEX = IDX_W'(BLOCK_SIZE - 1);
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(DATA_W - 1);

  // Component codes that select the luminance table.
  localparam logic [COMP_W-1:0] COMP_LUMA_Y  = 3'd0;
  localparam logic [COMP_W-1:0] COMP_LUMA_Y2 = 3'd4;

  typedef struct packed {
    logic signed [DATA_W-1:0] coefficient;
    logic [COMP_W-1:0]        component;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quantized;
    logic                     is_dc;
    logic                     last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_START,
    ST_DIV,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic store;
    logic read;
    logic start;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic div_done;
    logic idx_last;
    logic out_free;
  } dp_status_t;

  // Raster position of each zigzag position.
  localparam logic [IDX_W-1:0] ZZ_RASTER [BLOCK_SIZE] = '{
     0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
  };

  // Annex K luminance quantisation table, zigzag order.
  localparam logic [DIV_W-1:0] LUMA_Q [BLOCK_SIZE] = '{
     16,  11,  12,  14,  12,  10,  16,  14,  13,  14,  18,  17,  16,  19,  24,  40,
     26,  24,  22,  22,  24,  49,  35,  37,  29,  40,  58,  51,  61,  60,  57,  51,
     56,  55,  64,  72,  92,  78,  64,  68,  87,  69,  55,  56,  80, 109,  81,  87,
     95,  98, 103, 104, 103,  62,  77, 113, 121, 112, 100, 120,  92, 101, 103,  99
  };

  // Annex K chrominance quantisation table, zigzag order.
  localparam logic [DIV_W-1:0] CHROMA_Q [BLOCK_SIZE] = '{
     17,  18,  18,  24,  21,  24,  47,  26,  26,  47,  99,  66,  56,  66,  99,  99,
     99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,
     99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,
     99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99
  };

endpackage

/* sv/jzq_ram.sv */
module jzq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/jzq_ctrl.sv */
module jzq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  jzq_pkg::dp_status_t  status,
  output jzq_pkg::dp_cmd_t     cmd
);
  import jzq_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_valid && status.fill_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = status.idx_last ? ST_LOAD : ST_READ;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    cmd       = '0;
    case (state)
      ST_LOAD: begin
        in_stall  = 1'b0;
        cmd.store = in_valid;
      end
      ST_READ:  cmd.read  = 1'b1;
      ST_START: cmd.start = 1'b1;
      ST_DIV:   cmd.step  = 1'b1;
      ST_EMIT:  cmd.emit  = status.out_free;
      default: begin
        in_stall = 1'b1;
        cmd      = '0;
      end
    endcase
  end

endmodule

/* sv/jzq_datapath.sv */
module jzq_datapath #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  jzq_pkg::in_word_t    in_word,
  input  jzq_pkg::dp_cmd_t     cmd,
  output jzq_pkg::dp_status_t  status,
  input  logic                 out_stall,
  output logic                 out_valid,
  output jzq_pkg::out_word_t   out_word
);
  import jzq_pkg::*;

  logic [IDX_W-1:0]      fill_count;
  logic [IDX_W-1:0]      idx;
  logic                  luma_sel;
  logic                  neg;
  logic [DATA_W-1:0]     dvd;
  logic [DIV_W-1:0]      rem;
  logic [DIV_W-1:0]      divisor;
  logic [STEP_W-1:0]     step_cnt;
  logic [COEF_WIDTH-1:0] rd_data;

  logic signed [DATA_W-1:0] coef_ext;
  logic [DIV_W:0]           trial;
  logic                     take;
  logic [DIV_W-1:0]         rem_next;
  logic [DATA_W-1:0]        quot;

  jzq_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (BLOCK_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (fill_count),
    .wdata (in_word.coefficient[COEF_WIDTH-1:0]),
    .re    (cmd.read),
    .raddr (ZZ_RASTER[idx]),
    .rdata (rd_data)
  );

  // Only the low COEF_WIDTH bits of a coefficient are kept; they are
  // sign-extended when read back.
  assign coef_ext = DATA_W'($signed(rd_data));

  // One restoring step per cycle: the next dividend bit enters the remainder.
  assign trial    = {rem, dvd[DATA_W-1]};
  assign take     = trial >= {1'b0, divisor};
  assign rem_next = take ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
  assign quot     = neg ? DATA_W'(~dvd + 1'b1) : dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      idx        <= '0;
      step_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.store) begin
        fill_count <= fill_count + 1'b1;
      end
      if (cmd.start) begin
        step_cnt <= '0;
      end else if (cmd.step) begin
        step_cnt <= step_cnt + 1'b1;
      end
      if (cmd.emit) begin
        idx       <= idx + 1'b1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && fill_count == LAST_INDEX) begin
      luma_sel <= (in_word.component == COMP_LUMA_Y) ||
                  (in_word.component == COMP_LUMA_Y2);
    end
    if (cmd.start) begin
      neg     <= coef_ext[DATA_W-1];
      dvd     <= coef_ext[DATA_W-1] ? DATA_W'(~coef_ext + 1'b1) : DATA_W'(coef_ext);
      rem     <= '0;
      divisor <= luma_sel ? LUMA_Q[idx] : CHROMA_Q[idx];
    end else if (cmd.step) begin
      rem <= rem_next;
      dvd <= {dvd[DATA_W-2:0], take};
    end
    if (cmd.emit) begin
      out_word.quantized <= quot;
      out_word.is_dc     <= idx == '0;
      out_word.last      <= idx == LAST_INDEX;
    end
  end

  always_comb begin
    status.fill_last = fill_count == LAST_INDEX;
    status.div_done  = step_cnt == STEP_LAST;
    status.idx_last  = idx == LAST_INDEX;
    status.out_free  = !out_valid || !out_stall;
  end

endmodule

/* sv/jpeg_zigzag_quantizer_top.sv */
// The first word of a block is worked on once the 64th coefficient is taken. Each result
// then needs a read, a divider load, one restoring step per quotient bit in the shared
// divider, and a hand-over. No new block is taken before the last word is handed over.
// The radix-2 divider serves one coefficient at a time; the input waits meanwhile.
// Reset is synchronous and active high; it empties the fill count and the output stage.
// The coefficient store is not cleared; every entry is written before it is read.
module jpeg_zigzag_quantizer_top #(
  parameter int COEF_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  jzq_pkg::in_word_t  in_word,
  input  logic               in_valid,
  output logic               in_stall,
  output jzq_pkg::out_word_t out_word,
  output logic               out_valid,
  input  logic               out_stall
);
  import jzq_pkg::*;

  // Commands from the sequencer and the status it steers by.
  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller walks through loading the block and then, for each zigzag
  // position in turn, reads the stored coefficient, runs the divider and hands the
  // quotient to the output register. Input words are refused while results are
  // being produced, so the store is never overwritten under the reader.
  jzq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the coefficient store, the fill count, the zigzag index,
  // the quantisation tables and the sign-magnitude divider. Its output register
  // lets a finished word wait for the consumer while the next one is computed.
  jzq_datapath #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

/* sv/jzq_checker.sv */
module jzq_checker (
  input logic               clk,
  input logic               rst,
  input jzq_pkg::in_word_t  in_word,
  input logic               in_valid,
  input logic               in_stall,
  input jzq_pkg::out_word_t out_word,
  input logic               out_valid,
  input logic               out_stall
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // A stalled input word holds until the block takes it.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("input word changed while stalled");

  // No word is shown straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid just after reset");

  // A block has more than one word, so the first is never the last.
  a_dc_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.is_dc && out_word.last))
    else $error("word flagged both DC and last");

  // Input is refused while a block is still being emitted.
  a_no_load_mid_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.last |-> in_stall)
    else $error("input taken in the middle of a block");

endmodule

bind jpeg_zigzag_quantizer_top jzq_checker u_jzq_checker (.*);

/* sim/jpeg_zigzag_quantizer_top_test.sv */
module jpeg_zigzag_quantizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jzq_pkg::*;

  // The block runs at its full coefficient width. The model of the block below
  // still narrows each coefficient to COEF_W bits, so that a narrower build
  // only needs this one constant changed.
  localparam int COEF_W = 16;

  // Number of random words sent after the directed blocks.
  localparam int RANDOM_WORDS = 88;
  // The directed blocks and the random words, taken together.
  localparam int TOTAL_WORDS = 3 * BLOCK_SIZE + RANDOM_WORDS;

  // Each result takes its turn in the shared divider, and the receiver can add
  // a run of stall cycles on top of that. The limit below, counted in cycles with
  // no word moving on either channel, is far beyond any correct run.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles allowed after the last expected word, so that a stray word still shows.
  localparam int SETTLE_CYCLES = 60;
  // A broken block could flood the log, so only the first mismatches are printed.
  localparam int PRINT_LIMIT = 100;

  // Component codes. Only 0 and 4 select the luminance table. The rest select
  // the chrominance table, and that includes the codes that no image uses.
  localparam logic [COMP_W-1:0] COMP_CB     = 3'd1;
  localparam logic [COMP_W-1:0] COMP_SPARE5 = 3'd5;

  // Standard quantisation steps, listed in zigzag order.
  localparam int LUMA_STEP [BLOCK_SIZE] = '{
     16,  11,  12,  14,  12,  10,  16,  14,  13,  14,  18,  17,  16,  19,  24,  40,
     26,  24,  22,  22,  24,  49,  35,  37,  29,  40,  58,  51,  61,  60,  57,  51,
     56,  55,  64,  72,  92,  78,  64,  68,  87,  69,  55,  56,  80, 109,  81,  87,
     95,  98, 103, 104, 103,  62,  77, 113, 121, 112, 100, 120,  92, 101, 103,  99
  };
  localparam int CHROMA_STEP [BLOCK_SIZE] = '{
     17,  18,  18,  24,  21,  24,  47,  26,  26,  47,  99,  66,  56,  66,  99,  99,
     99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,
     99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,
     99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99,  99
  };

  // Each directed block is filled with one value. In a checker block, the
  // squares of odd parity carry the bitwise inverse of that value instead.
  // Where every quotient can be told at a glance, the row gives it, and the
  // row is checked against that value rather than against the model.
  typedef enum logic [0:0] {FILL_FLAT, FILL_CHECKER} fill_kind_t;

  typedef struct packed {
    fill_kind_t               kind;
    logic signed [DATA_W-1:0] value;
    logic [COMP_W-1:0]        component;
    logic                     known;
    logic signed [DATA_W-1:0] known_quotient;
  } block_row_t;

  // Rows, in order:
  //   1. A block of -1 with a spare code. Truncation toward zero gives 0 here,
  //      where rounding down would give -1.
  //   2. Full positive scale, luminance through its second code.
  //   3. Positive and negative extremes on alternate squares, chrominance.
  localparam block_row_t DIRECTED_ROWS [3] = '{
    '{FILL_FLAT,    16'shffff, COMP_SPARE5,  1'b1, 16'sh0000},
    '{FILL_FLAT,    16'sh7fff, COMP_LUMA_Y2, 1'b0, 16'sh0000},
    '{FILL_CHECKER, 16'sh7fff, COMP_CB,      1'b0, 16'sh0000}
  };

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  in_word_t   in_word   = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  out_word_t  out_word;
  logic       out_valid;
  logic       out_stall = 1'b0;

  // Idle rates, in percent. The stimulus process sets them for each phase.
  int send_idle_pct  = 7;
  int recv_stall_pct = 54;

  // This is the testbench's own copy of the block's state: the coefficient
  // store, the fill position and the zigzag walk. The zigzag walk is built
  // here by tracing the anti-diagonals, not copied from the design.
  logic signed [DATA_W-1:0] coef_store [BLOCK_SIZE];
  logic [IDX_W-1:0]         fill_pos = '0;
  logic [IDX_W-1:0]         zigzag_raster [BLOCK_SIZE];

  // These are the quantised words still to come, oldest first, and the
  // quotients that were typed in for some directed blocks, keyed by block number.
  out_word_t                pending_quotients [$];
  logic signed [DATA_W-1:0] known_quotients [int];
  int                       blocks_done = 0;

  int  mismatch_count = 0;
  int  idle_cycles    = 0;
  int  result_count   = 0;
  bit  moved;
  bit  timed_out;

  jpeg_zigzag_quantizer_top #(
    .COEF_WIDTH (COEF_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_word  (out_word),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  always #2 clk = ~clk;

  // Walk the anti-diagonals of the 8x8 block. On even diagonals the walk runs
  // upwards from the bottom row. On odd diagonals it runs downwards from the top.
  function automatic void build_zigzag();
    int pos;
    int lo;
    int hi;
    pos = 0;
    for (int s = 0; s < 15; s++) begin
      lo = (s > 7) ? s - 7 : 0;
      hi = (s < 7) ? s : 7;
      if (s % 2 == 0) begin
        for (int r = hi; r >= lo; r--) begin
          zigzag_raster[pos] = IDX_W'(r * 8 + (s - r));
          pos++;
        end
      end else begin
        for (int r = lo; r <= hi; r++) begin
          zigzag_raster[pos] = IDX_W'(r * 8 + (s - r));
          pos++;
        end
      end
    end
  endfunction

  // Only the low COEF_W bits of a coefficient count, and they are sign-extended.
  function automatic logic signed [DATA_W-1:0] narrow_coef(logic [DATA_W-1:0] raw);
    logic [COEF_W-1:0] low;
    low = raw[COEF_W-1:0];
    return DATA_W'(signed'(low));
  endfunction

  task automatic flag_mismatch(input string what, input logic signed [31:0] got,
                               input logic signed [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("%0t: result %0d, %s: got %0d, expected %0d",
               $realtime, result_count, what, got, want);
    end
  endtask

  // Store one accepted coefficient. On the 64th coefficient of a block, work
  // out all 64 quantised words in zigzag order. The component code of that
  // last word picks the table. Division of ints truncates toward zero, which
  // is what the block must do.
  task automatic absorb_coefficient(input in_word_t w);
    out_word_t q;
    bit        luma;
    int        c;
    int        d;
    coef_store[fill_pos] = narrow_coef(w.coefficient);
    if (fill_pos == LAST_INDEX) begin
      luma = (w.component == COMP_LUMA_Y) || (w.component == COMP_LUMA_Y2);
      for (int k = 0; k < BLOCK_SIZE; k++) begin
        c = coef_store[zigzag_raster[k]];
        d = luma ? LUMA_STEP[k] : CHROMA_STEP[k];
        q.quantized = DATA_W'(c / d);
        if (known_quotients.exists(blocks_done)) begin
          q.quantized = known_quotients[blocks_done];
        end
        q.is_dc = (k == 0);
        q.last  = (k == BLOCK_SIZE - 1);
        pending_quotients.push_back(q);
      end
      blocks_done++;
    end
    fill_pos = fill_pos + 1'b1;
  endtask

  task automatic compare_quantized_word(input out_word_t got);
    out_word_t want;
    if (pending_quotients.size() == 0) begin
      flag_mismatch("word with none expected", got.quantized, 0);
    end else begin
      want = pending_quotients.pop_front();
      if (got.quantized !== want.quantized) begin
        flag_mismatch("quantized", got.quantized, want.quantized);
      end
      if (got.is_dc !== want.is_dc) begin
        flag_mismatch("is_dc", got.is_dc, want.is_dc);
      end
      if (got.last !== want.last) begin
        flag_mismatch("last", got.last, want.last);
      end
    end
    result_count++;
  endtask

  // Both channels are sampled at the rising edge. The block's own registers
  // change only after this process has read them. The watchdog counts the
  // cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        absorb_coefficient(in_word);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        compare_quantized_word(out_word);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // The receiver stalls at random. The rate depends on the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // There are three phases, each about a third of the words. First the
  // receiver is the slow side. Then the sender is. In the last phase neither
  // side holds back, so the block runs flat out.
  function automatic void set_phase(input int word_idx);
    case (word_idx * 3 / TOTAL_WORDS)
      0: begin
        send_idle_pct  = 7;
        recv_stall_pct = 54;
      end
      1: begin
        send_idle_pct  = 54;
        recv_stall_pct = 7;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endfunction

  // Offer one word at the falling edge, after any idle cycles. The word is
  // held until a rising edge finds the stall low. The task returns at the
  // next falling edge. Only one value is ever scheduled for in_valid in a
  // given time step.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random coefficients are a mix of several kinds: full-width noise, small
  // values where truncation matters most, the extremes of the range, and
  // values that fall just around a multiple of a quantisation step. The
  // component code is random on every word, so the block has to ignore it
  // on all but the last word of a block.
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      w.coefficient = DATA_W'($urandom);
    end else if (pick < 80) begin
      w.coefficient = DATA_W'(int'($urandom_range(600)) - 300);
    end else if (pick < 90) begin
      case ($urandom_range(4))
        0:       w.coefficient = 16'sh7fff;
        1:       w.coefficient = 16'sh8000;
        2:       w.coefficient = 16'shffff;
        3:       w.coefficient = 16'sh0000;
        default: w.coefficient = 16'sh0001;
      endcase
    end else begin
      w.coefficient = DATA_W'((int'($urandom_range(40)) - 20) * int'($urandom_range(121, 10))
                              + int'($urandom_range(2)) - 1);
    end
    w.component = COMP_W'($urandom);
    return w;
  endfunction

  task automatic drive_stimulus();
    in_word_t   w;
    block_row_t row;
    int         word_idx;
    word_idx = 0;

    // The directed blocks come first. Every word before the last one carries
    // the inverse of the row's component code. For a luminance row that code
    // selects the other table, so a block that sampled the code early would
    // give wrong quotients.
    foreach (DIRECTED_ROWS[r]) begin
      row = DIRECTED_ROWS[r];
      if (row.known) begin
        known_quotients[r] = row.known_quotient;
      end
      for (int p = 0; p < BLOCK_SIZE; p++) begin
        set_phase(word_idx);
        if (row.kind == FILL_CHECKER && ((p / 8 + p % 8) % 2 == 1)) begin
          w.coefficient = ~row.value;
        end else begin
          w.coefficient = row.value;
        end
        w.component = (p == BLOCK_SIZE - 1) ? row.component : ~row.component;
        send_word(w);
        word_idx++;
      end
    end

    // The random words that follow form one whole block and a partial block at
    // the end. The partial block must give no words at all.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      set_phase(word_idx);
      send_word(random_word());
      word_idx++;
    end
    in_valid <= 1'b0;

    wait (pending_quotients.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    build_zigzag();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The run stops at whichever comes first: the stimulus and the drain
    // after it finish, or the watchdog runs out.
    fork
      drive_stimulus();
      wait (idle_cycles >= WATCHDOG_LIMIT);
    join_any
    disable fork;
    timed_out = (idle_cycles >= WATCHDOG_LIMIT);

    if (!timed_out && mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
